// ----- design/range_partition_classifier_assert.svh -----
// Assertion macros used by the checker file of the classifier.
`ifndef RANGE_PARTITION_CLASSIFIER_ASSERT_SVH
`define RANGE_PARTITION_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define RPC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define RPC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/rpc_pkg.sv -----
`default_nettype none

package rpc_pkg;

	localparam int DATA_W        = 64;
	localparam int ENTRY_INDEX_W = 8;
	localparam int BITS_W        = 7;
	localparam int BUCKET_W      = 8;
	localparam int COUNT_W       = 9;
	localparam int REG_INDEX_W   = 2;

	// Largest offset bit count; larger loaded values saturate to it.
	localparam logic [BITS_W-1:0] BITS_LIMIT = 7'd64;

	typedef enum logic {
		OP_LOAD     = 1'b0,
		OP_CLASSIFY = 1'b1
	} opcode_t;

	typedef enum logic [REG_INDEX_W-1:0] {
		REG_PARTITION_COUNT = 2'd0,
		REG_TOP_VALUE       = 2'd1,
		REG_ELEMENT_SIZE    = 2'd2
	} reg_index_t;

	typedef enum logic [1:0] {
		ESIZE_8  = 2'd0,
		ESIZE_16 = 2'd1,
		ESIZE_32 = 2'd2,
		ESIZE_64 = 2'd3
	} esize_t;

	function automatic logic [DATA_W-1:0] width_mask(input esize_t code);
		logic [DATA_W-1:0] m;
		case (code)
			ESIZE_8:  m = 64'h0000_0000_0000_00FF;
			ESIZE_16: m = 64'h0000_0000_0000_FFFF;
			ESIZE_32: m = 64'h0000_0000_FFFF_FFFF;
			default:  m = 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// ----- design/rpc_if.sv -----
`default_nettype none

interface rpc_item_if import rpc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	opcode_t                  opcode;
	logic [ENTRY_INDEX_W-1:0] entry_index;
	logic [DATA_W-1:0]        entry_base;
	logic [BITS_W-1:0]        entry_bits;
	logic [DATA_W-1:0]        sample;
	logic                     final_item;

	modport source (
		output valid, opcode, entry_index, entry_base, entry_bits, sample, final_item,
		input  ready
	);
	modport sink (
		input  valid, opcode, entry_index, entry_base, entry_bits, sample, final_item,
		output ready
	);
endinterface

interface rpc_result_if import rpc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [BUCKET_W-1:0] bucket;
	logic [DATA_W-1:0]   offset;
	logic [BITS_W-1:0]   offset_bits;
	logic                out_of_range;
	logic                is_last;

	modport source (
		output valid, bucket, offset, offset_bits, out_of_range, is_last,
		input  ready
	);
	modport sink (
		input  valid, bucket, offset, offset_bits, out_of_range, is_last,
		output ready
	);
endinterface

`default_nettype wire

// ----- design/range_partition_classifier.sv -----
// Range partition classifier.
// The item channel carries two kinds of transaction. A load transaction writes one
// entry of the partition table (base value and offset bit count) and completes in
// the cycle it is accepted, so loads may follow each other back to back. A classify
// transaction masks its sample to the element size and searches the table for the
// last base not above the value; the result channel then carries bucket, offset
// from that base, bit count, an out-of-range flag and the copied last marker.
// A classify checks its value against entry zero and, unless the value is out of
// range, then runs a binary search over the n partitions in use. The single table
// read port serves one search step per cycle, and the result of a classify is
// registered.
// While a result waits for the receiver the block still accepts loads and starts
// the next classify; only that classify's final cycle waits for the result register.
// Reset clears the control state and sets partition_count to 1, top_value to 0 and
// element_size to 64 bits. The table holds no defined contents after reset: every
// entry must be loaded before a search can reach it. The user must make register
// writes only while the block is idle; the block itself does not enforce this.
`default_nettype none

module range_partition_classifier import rpc_pkg::*; #(
	parameter int MAX_PARTITIONS = 256
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	rpc_item_if.sink                    item,
	rpc_result_if.source                result,
	input  wire logic                   wr_en,
	input  wire logic [REG_INDEX_W-1:0] wr_index,
	input  wire logic [DATA_W-1:0]      wr_data
);

	// Table address width and the width of a count that can hold the depth itself.
	localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
	localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);
	localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_PARTITIONS);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_CHECK  = 4'b0010,
		ST_SEARCH = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [COUNT_W-1:0] part_count_q;
	logic [DATA_W-1:0]  top_value_q;
	esize_t             elem_size_q;

	// Search context of the classify in flight.
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  lo_q;
	logic [CNT_W-1:0]  hi_q;
	logic [DATA_W-1:0] value_q;
	logic              last_q;
	logic              oor_q;
	logic [DATA_W-1:0] base_lo_q;
	logic [BITS_W-1:0] bits_lo_q;

	// Partition table and its registered read port.
	logic [DATA_W-1:0] base_mem [MAX_PARTITIONS];
	logic [BITS_W-1:0] bits_mem [MAX_PARTITIONS];
	logic [DATA_W-1:0] rd_base_q;
	logic [BITS_W-1:0] rd_bits_q;
	logic [IDX_W-1:0]  rd_addr;

	// Result register.
	logic                out_valid_q;
	logic [BUCKET_W-1:0] out_bucket_q;
	logic [DATA_W-1:0]   out_offset_q;
	logic [BITS_W-1:0]   out_bits_q;
	logic                out_oor_q;
	logic                out_last_q;

	logic              item_acc;
	logic              classify_acc;
	logic              load_en;
	logic [BITS_W-1:0] load_bits;
	logic [CNT_W-1:0]  used_n;
	logic [CNT_W-1:0]  mid;
	logic [CNT_W-1:0]  mid_p1;
	logic              go_up;
	logic [CNT_W-1:0]  step_lo;
	logic [CNT_W-1:0]  step_hi;
	logic [CNT_W-1:0]  step_mid_p1;
	logic              range_miss;
	logic              out_load;

	assign item.ready   = (state_q == ST_IDLE);
	assign item_acc     = item.valid && item.ready;
	assign classify_acc = item_acc && (item.opcode == OP_CLASSIFY);

	// A load beyond the table depth is dropped; bit counts above the limit saturate.
	assign load_en   = item_acc && (item.opcode == OP_LOAD)
		&& ({1'b0, item.entry_index} < MAX_CNT);
	assign load_bits = (item.entry_bits > BITS_LIMIT) ? BITS_LIMIT : item.entry_bits;

	// A partition count of zero means one entry; anything above the depth saturates.
	always_comb begin
		if (part_count_q == '0) begin
			used_n = CNT_W'(1);
		end else if (part_count_q > MAX_CNT) begin
			used_n = CNT_W'(MAX_PARTITIONS);
		end else begin
			used_n = CNT_W'(part_count_q);
		end
	end

	// One binary search step. The read data in hand is the base just above the
	// midpoint of the current interval, fetched in the previous cycle. The step is
	// only allowed to move up when that entry lies inside the partitions in use.
	assign mid    = lo_q + ((hi_q - lo_q) >> 1);
	assign mid_p1 = mid + CNT_W'(1);
	assign go_up  = (mid_p1 < n_q) && (rd_base_q <= value_q);

	always_comb begin
		if (state_q == ST_CHECK) begin
			step_lo = '0;
			step_hi = n_q;
		end else if (go_up) begin
			step_lo = mid_p1;
			step_hi = hi_q;
		end else begin
			step_lo = lo_q;
			step_hi = mid;
		end
	end

	// The address for the next cycle follows from the interval the current step
	// leaves behind, so the table serves one step per cycle. A classify starts by
	// reading entry zero, which bounds the range from below.
	assign step_mid_p1 = step_lo + ((step_hi - step_lo) >> 1) + CNT_W'(1);
	assign rd_addr     = (state_q == ST_IDLE) ? '0 : step_mid_p1[IDX_W-1:0];

	assign range_miss = (value_q < rd_base_q) || (value_q > top_value_q);

	// The result register takes a new result once the previous one has gone.
	assign out_load = (state_q == ST_FINISH) && (!out_valid_q || result.ready);

	always_ff @(posedge clk) begin
		if (load_en) begin
			base_mem[item.entry_index[IDX_W-1:0]] <= item.entry_base;
			bits_mem[item.entry_index[IDX_W-1:0]] <= load_bits;
		end
		rd_base_q <= base_mem[rd_addr];
		rd_bits_q <= bits_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_count_q <= COUNT_W'(1);
			top_value_q  <= '0;
			elem_size_q  <= ESIZE_64;
		end else if (wr_en) begin
			case (reg_index_t'(wr_index))
				REG_PARTITION_COUNT: part_count_q <= wr_data[COUNT_W-1:0];
				REG_TOP_VALUE:       top_value_q  <= wr_data;
				REG_ELEMENT_SIZE:    elem_size_q  <= esize_t'(wr_data[1:0]);
				default: begin
				end
			endcase
		end
	end

	// Sequencer: check the range against entry zero; if in range, halve the interval
	// once per cycle until it closes, then form the offset into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (classify_acc) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= range_miss ? ST_FINISH : ST_SEARCH;
				end
				ST_SEARCH: begin
					if (step_lo == step_hi) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (classify_acc) begin
			n_q     <= used_n;
			value_q <= item.sample & width_mask(elem_size_q);
			last_q  <= item.final_item;
		end
		if (state_q == ST_CHECK) begin
			lo_q      <= step_lo;
			hi_q      <= step_hi;
			oor_q     <= range_miss;
			base_lo_q <= rd_base_q;
			bits_lo_q <= rd_bits_q;
		end
		if (state_q == ST_SEARCH) begin
			lo_q <= step_lo;
			hi_q <= step_hi;
			// Moving up makes the entry just read the new candidate bucket.
			if (go_up) begin
				base_lo_q <= rd_base_q;
				bits_lo_q <= rd_bits_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_last_q <= last_q;
			out_oor_q  <= oor_q;
			if (oor_q) begin
				out_bucket_q <= '0;
				out_offset_q <= '0;
				out_bits_q   <= '0;
			end else begin
				out_bucket_q <= BUCKET_W'(lo_q);
				out_offset_q <= value_q - base_lo_q;
				out_bits_q   <= bits_lo_q;
			end
		end
	end

	assign result.valid        = out_valid_q;
	assign result.bucket       = out_bucket_q;
	assign result.offset       = out_offset_q;
	assign result.offset_bits  = out_bits_q;
	assign result.out_of_range = out_oor_q;
	assign result.is_last      = out_last_q;

endmodule

`default_nettype wire

// ----- design/rpc_checker.sv -----
`default_nettype none
`include "range_partition_classifier_assert.svh"

module rpc_checker import rpc_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                item_valid,
	input wire logic                item_ready,
	input wire opcode_t             item_opcode,
	input wire logic                result_valid,
	input wire logic                result_ready,
	input wire logic [BUCKET_W-1:0] result_bucket,
	input wire logic [DATA_W-1:0]   result_offset,
	input wire logic [BITS_W-1:0]   result_offset_bits,
	input wire logic                result_out_of_range,
	input wire logic                result_is_last
);

	// A result that is not taken keeps its contents.
	`RPC_ASSERT_NXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result_bucket) && $stable(result_offset) && $stable(result_offset_bits) && $stable(result_out_of_range) && $stable(result_is_last), "result changed while stalled")

	// A classify occupies the block: it is not ready in the following cycle.
	`RPC_ASSERT_NXT(a_classify_busy, clk, arst_n, item_valid && item_ready && (item_opcode == OP_CLASSIFY), !item_ready, "ready right after a classify")

	// A load completes at once and leaves the block ready.
	`RPC_ASSERT_NXT(a_load_ready, clk, arst_n, item_valid && item_ready && (item_opcode == OP_LOAD), item_ready, "not ready after a load")

	// A fresh result only appears at the end of a classify, while the block is busy.
	`RPC_ASSERT_IMP(a_result_origin, clk, arst_n, $rose(result_valid), !$past(item_ready), "result appeared while idle")

endmodule

bind range_partition_classifier rpc_checker u_rpc_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.item_valid          (item.valid),
	.item_ready          (item.ready),
	.item_opcode         (item.opcode),
	.result_valid        (result.valid),
	.result_ready        (result.ready),
	.result_bucket       (result.bucket),
	.result_offset       (result.offset),
	.result_offset_bits  (result.offset_bits),
	.result_out_of_range (result.out_of_range),
	.result_is_last      (result.is_last)
);

`default_nettype wire
